// ===== sv/dhoat_pkg.sv =====
// Package: shared types and codes for the double-hash open-address table.
`timescale 1ns / 1ps
package dhoat_pkg;

  localparam int CMD_BITS    = 2;
  localparam int KEY_W       = 31;
  localparam int STATUS_BITS = 2;
  localparam int SLOT_W      = 6;
  localparam int SIZE_BITS   = 7;

  localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0] command;
    logic [KEY_W-1:0]    key;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_W-1:0]      slot;
  } out_item_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_CLEAR, BK_DIV, BK_READ, BK_WAIT, BK_CHECK, BK_OUT
  } bk_state_t;

endpackage

// ===== sv/dhoat_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module dhoat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/dhoat_front.sv =====
// Front end: two-entry queue of accepted commands ahead of the probe engine.
`timescale 1ns / 1ps
module dhoat_front import dhoat_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_item_t q_data
);
  in_item_t   buf0, buf1;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
    if (q_pop) begin
      buf0 <= (count == 2'd2) ? buf1 : in_data;
      if (push) begin
        if (count == 2'd2) buf1 <= in_data;
      end
    end else if (push) begin
      if (count == 2'd0) buf0 <= in_data;
      else               buf1 <= in_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 2'd1) else $error("push lost");
`endif
endmodule

// ===== sv/dhoat_back.sv =====
// Back end: iterative remainders, probe loop, clearing and result register.
`timescale 1ns / 1ps
module dhoat_back import dhoat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SIZE_BITS-1:0] table_size,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  in_item_t             q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  output logic                 busy
);
  localparam int AW = $clog2(CAPACITY);
  localparam int MW = AW + 1;

  bk_state_t state, state_next;
  in_item_t  cur;
  logic [MW-1:0]   m, m1, probes;
  logic [MW-1:0]   rem_a, rem_b;
  logic [5:0]      bitn;
  logic [AW-1:0]   pos, step;
  logic [CAPACITY-1:0] used;
  logic [KEY_W-1:0] rdata;
  out_item_t       res;
  logic            res_valid;
  logic            ram_we;
  logic [MW:0]     ta, tb, sum;
  logic [MW-1:0]   m_eff;

  always_comb begin
    if (table_size < SIZE_BITS'(2)) m_eff = MW'(2);
    else if ({1'b0, table_size} > 8'(CAPACITY)) m_eff = MW'(CAPACITY);
    else m_eff = MW'(table_size);
  end

  // one restoring-division bit per cycle for both moduli
  assign ta  = {rem_a, cur.key[bitn[4:0]]};
  assign tb  = {rem_b, cur.key[bitn[4:0]]};
  assign sum = {1'b0, pos} + {1'b0, step};

  assign ram_we = (state == BK_CHECK) && (cur.command == CMD_INSERT) && !used[pos];

  dhoat_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(ram_we), .waddr(pos), .wdata(cur.key),
    .raddr(pos), .rdata(rdata));

  assign out_valid = res_valid;
  assign out_data  = res;
  assign busy      = (state != BK_IDLE) || res_valid;
  assign q_pop     = (state == BK_IDLE) && q_valid && !res_valid;

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:  if (q_pop) state_next = (q_data.command == CMD_CLEAR) ? BK_CLEAR :
                  (q_data.command == CMD_INSERT || q_data.command == CMD_SEARCH) ?
                  BK_DIV : BK_OUT;
      BK_CLEAR: state_next = BK_OUT;
      BK_DIV:   if (bitn == 6'd0) state_next = BK_READ;
      BK_READ:  state_next = BK_WAIT;
      BK_WAIT:  state_next = BK_CHECK;
      BK_CHECK: begin
        if (!used[pos]) state_next = BK_OUT;
        else if (cur.command == CMD_SEARCH && rdata == cur.key) state_next = BK_OUT;
        else if (probes == m - MW'(1)) state_next = BK_OUT;
        else state_next = BK_WAIT;
      end
      BK_OUT:   state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
      used      <= '0;
    end else begin
      state <= state_next;
      if (res_valid && !out_stall) res_valid <= 1'b0;
      case (state)
        BK_IDLE: if (q_pop) begin
          cur      <= q_data;
          m        <= m_eff;
          m1       <= m_eff - MW'(1);
          rem_a    <= '0;
          rem_b    <= '0;
          bitn     <= 6'(KEY_W - 1);
          probes   <= '0;
          res      <= '{status: ST_OK, slot: '0};
        end
        BK_CLEAR: used <= '0;
        BK_DIV: begin
          rem_a <= (ta >= {1'b0, m})  ? MW'(ta - {1'b0, m})  : ta[MW-1:0];
          rem_b <= (tb >= {1'b0, m1}) ? MW'(tb - {1'b0, m1}) : tb[MW-1:0];
          bitn  <= bitn - 6'd1;
        end
        BK_READ: begin
          pos  <= rem_a[AW-1:0];
          step <= AW'(rem_b + MW'(1));
          res  <= '{status: (cur.command == CMD_INSERT) ? ST_FULL : ST_NOTFOUND,
                    slot: '0};
        end
        BK_CHECK: begin
          if (cur.command == CMD_INSERT && !used[pos]) begin
            used[pos] <= 1'b1;
            res <= '{status: ST_OK, slot: SLOT_W'(pos)};
          end else if (cur.command == CMD_SEARCH && used[pos] && rdata == cur.key) begin
            res <= '{status: ST_OK, slot: SLOT_W'(pos)};
          end
          probes <= probes + MW'(1);
          pos <= (sum >= {1'b0, m}) ? AW'(sum - {1'b0, m}) : AW'(sum);
        end
        BK_OUT: res_valid <= 1'b1;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == BK_CHECK |-> {1'b0, pos} < m) else $error("probe outside table");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_stall |=> res_valid && $stable(res)) else $error("result dropped");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !res_valid) else $error("pop while result pending");
`endif
endmodule

// ===== sv/double_hash_open_address_table.sv =====
// Top level: double-hash open-address table, front queue plus probe engine.
// Operation: clear empties the table; insert/search run one 31-step
//   remainder pass, then up to m probes through the key RAM.
// Ordering: one command at a time in the probe engine; a new one starts
//   only after the last result has been taken by the receiver.
// Reset (rst, synchronous): table empty, table_size = 31, queue flushed.
`timescale 1ns / 1ps
module double_hash_open_address_table import dhoat_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [SIZE_BITS-1:0] cfg_data
);
  logic [SIZE_BITS-1:0] table_size;
  logic     q_valid, q_pop, busy;
  in_item_t q_data;

  // size register; writes only land while idle
  assign cfg_ready = !busy && !q_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_BITS'(31);
    end else if (cfg_valid && cfg_ready) begin
      table_size <= cfg_data;
    end
  end

  dhoat_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data));

  dhoat_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .table_size(table_size), .q_valid(q_valid),
    .q_pop(q_pop), .q_data(q_data), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data), .busy(busy));

`ifndef SYNTHESIS
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> busy) else $error("result without work");
  a_rst_size: assert property (@(posedge clk)
    $past(rst) |-> table_size == SIZE_BITS'(31)) else $error("size reset");
  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid |=> $stable(table_size)) else $error("size changed");
`endif
endmodule

// ===== tb/testbench.sv =====
// Testbench for the double-hash open-address table: directed and random traffic.
`timescale 1ns / 1ps
module testbench;
  import dhoat_pkg::*;

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 20000;

  // Expected-result store plus a copy of the table contents.
  class hash_table_scoreboard;
    logic [KEY_W-1:0] keys [CAP];
    bit               used [CAP];
    logic [SIZE_BITS-1:0] size_reg;
    out_item_t        pending [$];
    int               errors;

    function new();
      size_reg = 7'd31;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function int active_size();
      if (size_reg < 2) return 2;
      if (size_reg > CAP) return CAP;
      return int'(size_reg);
    endfunction

    // Apply an accepted command and queue what it should produce.
    function void note_command(in_item_t it);
      int m, pos, stride;
      out_item_t r;
      m = active_size();
      pos = it.key % m;
      stride = 1 + it.key % (m - 1);
      r.status = ST_OK;
      r.slot = '0;
      if (it.command == CMD_CLEAR) begin
        foreach (used[i]) used[i] = 0;
      end else if (it.command == CMD_INSERT) begin
        r.status = ST_FULL;
        for (int i = 0; i < m; i++) begin
          if (!used[pos]) begin
            used[pos] = 1;
            keys[pos] = it.key;
            r.status = ST_OK;
            r.slot = SLOT_W'(pos);
            break;
          end
          pos = (pos + stride) % m;
        end
      end else if (it.command == CMD_SEARCH) begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < m; i++) begin
          if (!used[pos]) break;
          if (keys[pos] == it.key) begin
            r.status = ST_OK;
            r.slot = SLOT_W'(pos);
            break;
          end
          pos = (pos + stride) % m;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        $error("result with nothing expected: status %0d slot %0d", got.status, got.slot);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.slot !== exp_r.slot) begin
        $error("slot: expected %0d, got %0d", exp_r.slot, got.slot);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [SIZE_BITS-1:0] cfg_data = '0;

  hash_table_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;    // long receiver hold-off request
  bit [KEY_W-1:0] recent_keys [$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  double_hash_open_address_table #(.CAPACITY(CAP)) DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  // Sample results and count quiet cycles for the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Receiver: random stall per transfer, plus a long hold-off on request.
  initial begin
    int gap;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_command(logic [CMD_BITS-1:0] c, logic [KEY_W-1:0] k, bit gaps);
    in_item_t it;
    int gap;
    it.command = c;
    it.key = k;
    gap = gaps ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk iff !in_stall);
    sb.note_command(it);
  endtask

  task automatic write_size(logic [SIZE_BITS-1:0] v);
    in_valid <= 0;
    wait (sb.pending.size() == 0);
    repeat (200) @(posedge clk);   // probe engine fully at rest
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    sb.size_reg = v;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 7) return KEY_W'($urandom_range(0, 200));
    return KEY_W'($urandom());
  endfunction

  initial begin
    logic [SIZE_BITS-1:0] sizes [8] = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd64, 7'd5, 7'd31, 7'd17};
    logic [KEY_W-1:0] k;
    logic [CMD_BITS-1:0] c;
    int r;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: key extremes, every command, unused command, full table.
    send_command(CMD_SEARCH, '0, 0);
    send_command(CMD_INSERT, '0, 0);
    send_command(CMD_INSERT, {KEY_W{1'b1}}, 0);
    send_command(CMD_INSERT, {KEY_W{1'b1}}, 0);   // duplicate stored again
    send_command(CMD_SEARCH, {KEY_W{1'b1}}, 0);
    send_command(CMD_SEARCH, 31'h5555_5555, 0);
    send_command(CMD_UNUSED, 31'h2aaa_aaaa, 0);
    send_command(CMD_CLEAR, 31'h1234, 0);
    send_command(CMD_SEARCH, '0, 0);
    write_size(7'd2);
    send_command(CMD_INSERT, 31'd7, 0);
    send_command(CMD_INSERT, 31'd8, 0);
    send_command(CMD_INSERT, 31'd9, 0);   // full
    send_command(CMD_SEARCH, 31'd9, 0);   // all probed, not found
    send_command(CMD_SEARCH, 31'd8, 0);
    write_size(7'd3);
    send_command(CMD_SEARCH, 31'd8, 0);   // size grown while filled
    send_command(CMD_CLEAR, '0, 0);

    // Long receiver hold-off while commands keep coming.
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_command(CMD_INSERT, KEY_W'($urandom_range(0, 500)), 0);

    // Random phases over several sizes.
    for (int p = 0; p < 8; p++) begin
      write_size(sizes[p]);
      recent_keys.delete();
      for (int i = 0; i < 228; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) c = CMD_CLEAR;
        else if (r < 5) c = CMD_UNUSED;
        else if (r < 55) c = CMD_INSERT;
        else c = CMD_SEARCH;
        k = pick_key();
        if (c == CMD_INSERT) recent_keys.push_back(k);
        send_command(c, k, (i % 60) >= 15);
      end
    end
    in_valid <= 0;

    wait (sb.pending.size() == 0);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end
endmodule
